[hdl/assert_macros.svh]
// Assertion helpers for the detector RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ALPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication from a condition to a property on the next edge.
`define ALPD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[hdl/alpd_pkg.sv]
package alpd_pkg;

    localparam int DELTA_W    = 16;
    localparam int TIME_W     = 24;
    localparam int SHIFT_W    = 4;
    localparam int CONTRAST_W = 10;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [SHIFT_W-1:0]    EASE_SHIFT_RST   = 4'd13;
    localparam logic [CONTRAST_W-1:0] MIN_CONTRAST_RST = 10'd200;
    localparam logic [TIME_W-1:0]     HOLD_MS_RST      = 24'd1000;
    localparam logic [TIME_W-1:0]     TIMEOUT_MS_RST   = 24'd60000;
    localparam logic [TIME_W-1:0]     TIME_SAT         = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        REG_EASE_SHIFT   = 2'd0,
        REG_MIN_CONTRAST = 2'd1,
        REG_HOLD_MS      = 2'd2,
        REG_TIMEOUT_MS   = 2'd3
    } cfg_reg_t;

endpackage

[hdl/alpd_if.sv]
interface alpd_in_if #(
    parameter int SAMPLE_BITS = 10
);
    import alpd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic [DELTA_W-1:0]     delta_ms;

    modport source (output valid, output sample, output delta_ms, input ready);
    modport sink   (input valid, input sample, input delta_ms, output ready);
endinterface

interface alpd_out_if;
    import alpd_pkg::*;

    logic              valid;
    logic              ready;
    logic              dark;
    logic              lit_start;
    logic              lit_end;
    logic [TIME_W-1:0] lit_duration;
    logic              hold_reached;
    logic              timed_out;

    modport source (
        output valid, output dark, output lit_start, output lit_end,
        output lit_duration, output hold_reached, output timed_out, input ready
    );
    modport sink (
        input valid, input dark, input lit_start, input lit_end,
        input lit_duration, input hold_reached, input timed_out, output ready
    );
endinterface

[hdl/adaptive_light_pulse_detector.sv]
// An accepted sample beat passes the input register, then the result register, to become its result beat.
// Throughput: 1 sample per cycle while the sink is ready; the average/envelope update is combinational.
// Stalls: the result register holds while the sink is not ready; the input register then fills and holds.
// Reset (rst_n, asynchronous, active low): average and high envelope to zero, low envelope to full scale,
// lit and elapsed counters to zero, registers to ease_shift 13, min_contrast 200, hold 1000, timeout 60000.
`include "assert_macros.svh"

module adaptive_light_pulse_detector #(
    parameter int SAMPLE_BITS = 10,
    parameter int FRAC_BITS   = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    alpd_in_if.sink                            samples,
    alpd_out_if.source                         events,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [alpd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [alpd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [alpd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import alpd_pkg::*;

    // Level format: unsigned Q(SAMPLE_BITS).(FRAC_BITS); arithmetic done two bits wider, signed.
    localparam int LW = SAMPLE_BITS + FRAC_BITS;
    localparam int WW = LW + 2;
    localparam logic [LW-1:0] LEVEL_MAX = {{SAMPLE_BITS{1'b1}}, {FRAC_BITS{1'b0}}};

    // Step toward target by floor((target - cur) / 2^s): an arithmetic shift of the difference.
    function automatic logic [LW-1:0] ease(
        input logic [LW-1:0]      cur,
        input logic [LW-1:0]      tgt,
        input logic [SHIFT_W-1:0] s
    );
        logic signed [WW-1:0] diff;
        logic signed [WW-1:0] res;
        diff = $signed({2'b00, tgt}) - $signed({2'b00, cur});
        res  = $signed({2'b00, cur}) + (diff >>> s);
        return res[LW-1:0];
    endfunction

    // ---------------------------------------------------------------------
    // Configuration registers (APB, zero wait states)
    // ---------------------------------------------------------------------
    logic [SHIFT_W-1:0]    ease_shift_reg;
    logic [CONTRAST_W-1:0] min_contrast_reg;
    logic [TIME_W-1:0]     hold_ms_reg;
    logic [TIME_W-1:0]     timeout_ms_reg;
    logic                  cfg_wr;
    cfg_reg_t              cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ease_shift_reg   <= EASE_SHIFT_RST;
            min_contrast_reg <= MIN_CONTRAST_RST;
            hold_ms_reg      <= HOLD_MS_RST;
            timeout_ms_reg   <= TIMEOUT_MS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_EASE_SHIFT:   ease_shift_reg   <= pwdata[SHIFT_W-1:0];
                REG_MIN_CONTRAST: min_contrast_reg <= pwdata[CONTRAST_W-1:0];
                REG_HOLD_MS:      hold_ms_reg      <= pwdata[TIME_W-1:0];
                REG_TIMEOUT_MS:   timeout_ms_reg   <= pwdata[TIME_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_sel)
            REG_EASE_SHIFT:   prdata[SHIFT_W-1:0]    = ease_shift_reg;
            REG_MIN_CONTRAST: prdata[CONTRAST_W-1:0] = min_contrast_reg;
            REG_HOLD_MS:      prdata[TIME_W-1:0]     = hold_ms_reg;
            REG_TIMEOUT_MS:   prdata[TIME_W-1:0]     = timeout_ms_reg;
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Handshake: the input register advances whenever the result register
    // is empty or being drained this cycle, so a beat moves every cycle while the sink is ready.
    // ---------------------------------------------------------------------
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [DELTA_W-1:0]     delta_reg;
    logic                   out_valid_reg;
    logic                   advance;
    logic                   step;

    assign advance       = !out_valid_reg || events.ready;
    assign samples.ready = !in_valid_reg || advance;
    assign step          = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    // Payload only: capture on every accepted beat.
    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            sample_reg <= samples.sample;
            delta_reg  <= samples.delta_ms;
        end
    end

    // ---------------------------------------------------------------------
    // Tracker state and the single-pass update
    // ---------------------------------------------------------------------
    logic [LW-1:0]     avg_reg;
    logic [LW-1:0]     low_reg;
    logic [LW-1:0]     high_reg;
    logic [TIME_W-1:0] lit_reg;
    logic [TIME_W-1:0] elapsed_reg;

    logic [LW-1:0]        level;
    logic [LW-1:0]        avg_next;
    logic [LW-1:0]        low_snap;
    logic [LW-1:0]        high_snap;
    logic [LW-1:0]        low_next;
    logic [LW-1:0]        high_next;
    logic signed [WW-1:0] span;
    logic signed [WW-1:0] mid;
    logic [WW-1:0]        contrast_thr;
    logic                 dark_c;
    logic [TIME_W:0]      lit_sum;
    logic [TIME_W:0]      elapsed_sum;
    logic [TIME_W-1:0]    lit_next;
    logic [TIME_W-1:0]    elapsed_next;

    always_comb
    begin
        level = {sample_reg, {FRAC_BITS{1'b0}}};

        // Average first, then snap the envelopes outward and ease them toward it.
        avg_next  = ease(avg_reg, level, ease_shift_reg);
        high_snap = (level > high_reg) ? level : high_reg;
        low_snap  = (level < low_reg) ? level : low_reg;
        low_next  = ease(low_snap, avg_next, ease_shift_reg);
        high_next = ease(high_snap, avg_next, ease_shift_reg);

        // Midpoint rounds toward minus infinity; crossed envelopes give a negative span.
        span         = $signed({2'b00, high_next}) - $signed({2'b00, low_next});
        mid          = $signed({2'b00, low_next}) + (span >>> 1);
        contrast_thr = {{(WW-CONTRAST_W){1'b0}}, min_contrast_reg} << FRAC_BITS;
        dark_c       = ($signed({2'b00, level}) > mid) || (span < $signed({1'b0, contrast_thr}));

        lit_sum      = {1'b0, lit_reg} + {{(TIME_W+1-DELTA_W){1'b0}}, delta_reg};
        elapsed_sum  = {1'b0, elapsed_reg} + {{(TIME_W+1-DELTA_W){1'b0}}, delta_reg};
        lit_next     = dark_c ? '0 : (lit_sum[TIME_W] ? TIME_SAT : lit_sum[TIME_W-1:0]);
        elapsed_next = elapsed_sum[TIME_W] ? TIME_SAT : elapsed_sum[TIME_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg     <= '0;
            low_reg     <= LEVEL_MAX;
            high_reg    <= '0;
            lit_reg     <= '0;
            elapsed_reg <= '0;
        end
        else if (step)
        begin
            avg_reg     <= avg_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            lit_reg     <= lit_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    logic              dark_reg;
    logic              lit_start_reg;
    logic              lit_end_reg;
    logic [TIME_W-1:0] lit_duration_reg;
    logic              hold_reached_reg;
    logic              timed_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            dark_reg         <= dark_c;
            lit_start_reg    <= !dark_c && (lit_reg == '0);
            lit_end_reg      <= dark_c && (lit_reg != '0);
            lit_duration_reg <= lit_next;
            hold_reached_reg <= lit_next > hold_ms_reg;
            timed_out_reg    <= elapsed_next > timeout_ms_reg;
        end
    end

    assign events.valid        = out_valid_reg;
    assign events.dark         = dark_reg;
    assign events.lit_start    = lit_start_reg;
    assign events.lit_end      = lit_end_reg;
    assign events.lit_duration = lit_duration_reg;
    assign events.hold_reached = hold_reached_reg;
    assign events.timed_out    = timed_out_reg;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    `ALPD_ASSERT(a_edges_match_dark, !out_valid_reg || ((!lit_start_reg || !dark_reg) && (!lit_end_reg || dark_reg)), "edge flag disagrees with dark")
    `ALPD_ASSERT(a_dark_clears_lit, !out_valid_reg || !dark_reg || (lit_duration_reg == '0), "dark result with nonzero lit duration")
    `ALPD_ASSERT(a_envelopes_in_range, (low_reg <= LEVEL_MAX) && (high_reg <= LEVEL_MAX) && (avg_reg <= LEVEL_MAX), "level left full scale")
    `ALPD_ASSERT_NEXT(a_elapsed_monotone, step, elapsed_reg >= $past(elapsed_reg), "elapsed time went backwards")

endmodule
